/* rtl/bfa_pkg.sv */
// Shared types and constants for the bump frame allocator.
// No dependencies.
`default_nettype none

package bfa_pkg;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 4;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_MEM_START = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_MEM_END   = 4'd1;

  // controller -> datapath
  typedef struct packed {
    logic    load_in;
    logic    init_walk;
    logic    walk_step;
    logic    commit_alloc;
    logic    restart;
    logic    mod_start;
    logic    add_write;
    logic    res_load;
    logic    res_frame_sel;
    status_e res_status;
  } bfa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             oom;
    logic             table_full;
    logic             count_zero;
    logic             walk_last;
    logic             mod_done;
    logic             out_free;
  } bfa_stat_t;

endpackage

`default_nettype wire

/* rtl/bfa_intf.sv */
// Handshake channel interfaces: item input, result output, config write.
// Depends on bfa_pkg.
`default_nettype none

interface bfa_in_if
  import bfa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic [AddrW-1:0]         region_first;
  logic [AddrW-1:0]         region_last;

  modport source (output valid, mode, region_first, region_last, input ready);
  modport sink   (input valid, mode, region_first, region_last, output ready);
endinterface

interface bfa_out_if
  import bfa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [AddrW-1:0]         frame_address;
  logic [StatusW-1:0]       status;

  modport source (output valid, frame_address, status, input ready);
  modport sink   (input valid, frame_address, status, output ready);
endinterface

interface bfa_cfg_if
  import bfa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CfgIdxW-1:0]       index;
  logic [AddrW-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/bfa_rem.sv */
// Remainder of a 48-bit address by the constant frame size, pipelined:
// nibble fold against 16^k residues, then two compare-subtract stages.
// Depends on bfa_pkg.
`default_nettype none

module bfa_rem
  import bfa_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AddrW-1:0] dividend_i,
  output logic                  done_o,
  output logic [$clog2(FRAME_BYTES):0] rem_o
);

  localparam int unsigned RemW  = $clog2(FRAME_BYTES) + 1;
  localparam int unsigned NibN  = AddrW / 4;
  localparam int unsigned FoldW = RemW + 8;
  localparam logic [FoldW-1:0] Div = FoldW'(FRAME_BYTES);

  // residue of 16^k for each nibble position
  function automatic logic [NibN*RemW-1:0] nib_residues();
    logic [NibN*RemW-1:0] res;
    logic [63:0]          r;
    res = '0;
    r   = 64'd1 % 64'(FRAME_BYTES);
    for (int k = 0; k < int'(NibN); k++) begin
      res[k*RemW +: RemW] = RemW'(r);
      r = (r << 4) % 64'(FRAME_BYTES);
    end
    return res;
  endfunction

  localparam logic [NibN*RemW-1:0] NibRes = nib_residues();

  logic [FoldW-1:0] sum_q, sum_d;
  logic [FoldW-1:0] mid_q, mid_d;
  logic [FoldW-1:0] low_red;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             v1_q, v2_q, done_q;

  // folded sum stays below 256 frames, so eight subtract steps finish it
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < int'(NibN); k++) begin
      sum_d = sum_d + FoldW'(dividend_i[4*k +: 4]) * FoldW'(NibRes[k*RemW +: RemW]);
    end
  end

  always_comb begin
    mid_d = sum_q;
    for (int j = 7; j >= 4; j--) begin
      if (mid_d >= (Div << j)) begin
        mid_d = mid_d - (Div << j);
      end
    end
    low_red = mid_q;
    for (int j = 3; j >= 0; j--) begin
      if (low_red >= (Div << j)) begin
        low_red = low_red - (Div << j);
      end
    end
    rem_d = low_red[RemW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
    end
    if (v1_q) begin
      mid_q <= mid_d;
    end
    if (v2_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/bfa_dp.sv */
// Datapath: config registers, frame pointer, reserved region table, walk
// compare, result register. Depends on bfa_pkg and bfa_rem.
`default_nettype none

module bfa_dp
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned FRAME_BYTES = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bfa_cmd_t           cmd_i,
  output bfa_stat_t               stat_o,
  input  wire logic [ModeW-1:0]   in_mode_i,
  input  wire logic [AddrW-1:0]   in_first_i,
  input  wire logic [AddrW-1:0]   in_last_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [AddrW-1:0]   cfg_data_i,
  output logic                    cfg_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [AddrW-1:0]        out_frame_o,
  output logic [StatusW-1:0]      out_status_o
);

  localparam int unsigned CntW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned PtrW = AddrW + 1;
  localparam int unsigned RemW = $clog2(FRAME_BYTES) + 1;
  localparam logic [PtrW-1:0] Frame = PtrW'(FRAME_BYTES);

  logic [AddrW-1:0]   mem_start_q, mem_end_q;
  logic [AddrW-1:0]   next_frame_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    walk_idx_q;
  logic [PtrW-1:0]    p_q;
  logic [AddrW-1:0]   alloc_frame_q;
  logic [ModeW-1:0]   mode_q;
  logic [AddrW-1:0]   first_q, last_q;
  logic               out_valid_q;
  logic [AddrW-1:0]   out_frame_q;
  logic [StatusW-1:0] out_status_q;

  logic [AddrW-1:0]   rs_mem [MAX_REGIONS];
  logic [AddrW-1:0]   re_mem [MAX_REGIONS];
  logic [PtrW-1:0]    sk_mem [MAX_REGIONS];
  logic [AddrW-1:0]   rs_rd_q, re_rd_q;
  logic [PtrW-1:0]    sk_rd_q;

  logic               mod_done;
  logic [RemW-1:0]    mod_rem;
  logic [PtrW-1:0]    skip_new;
  logic [PtrW-1:0]    q_ptr, s_ext, e_ext, p_adv;
  logic               overlap;
  logic               walk_last;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic [CntW-1:0]    walk_nxt;

  bfa_rem #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (last_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign skip_new  = PtrW'(last_q) - PtrW'(mod_rem) + Frame;
  assign q_ptr     = p_q + Frame;
  assign s_ext     = PtrW'(rs_rd_q);
  assign e_ext     = PtrW'(re_rd_q);
  assign overlap   = (p_q >= s_ext && p_q <= e_ext) ||
                     (q_ptr > s_ext && q_ptr <= e_ext) ||
                     (p_q <= s_ext && q_ptr >= e_ext);
  assign walk_last = (walk_idx_q == count_q - 1'b1);
  assign walk_nxt  = walk_idx_q + 1'b1;
  assign p_adv     = p_q + Frame;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.init_walk) begin
      rd_en = 1'b1;
    end else if (cmd_i.walk_step && !walk_last) begin
      rd_en   = 1'b1;
      rd_addr = walk_nxt[IdxW-1:0];
    end
  end

  // region table
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      rs_mem[count_q[IdxW-1:0]] <= first_q;
      re_mem[count_q[IdxW-1:0]] <= last_q;
      sk_mem[count_q[IdxW-1:0]] <= skip_new;
    end
    if (rd_en) begin
      rs_rd_q <= rs_mem[rd_addr];
      re_rd_q <= re_mem[rd_addr];
      sk_rd_q <= sk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_start_q  <= '0;
      mem_end_q    <= '0;
      next_frame_q <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MEM_START) begin
          mem_start_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_MEM_END) begin
          mem_end_q <= cfg_data_i;
        end
      end
      if (cmd_i.restart) begin
        next_frame_q <= mem_start_q;
        count_q      <= '0;
      end else if (cmd_i.add_write) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.commit_alloc) begin
        next_frame_q <= p_adv[AddrW-1:0];
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q  <= in_mode_i;
      first_q <= in_first_i;
      last_q  <= in_last_i;
    end
    if (cmd_i.init_walk) begin
      p_q        <= PtrW'(next_frame_q);
      walk_idx_q <= '0;
    end else if (cmd_i.walk_step) begin
      if (overlap) begin
        p_q <= sk_rd_q;
      end
      walk_idx_q <= walk_nxt;
    end
    if (cmd_i.commit_alloc) begin
      alloc_frame_q <= p_q[AddrW-1:0];
    end
    if (cmd_i.res_load) begin
      out_frame_q  <= cmd_i.res_frame_sel ? alloc_frame_q : '0;
      out_status_q <= cmd_i.res_status;
    end
  end

  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.oom        = (PtrW'(next_frame_q) + Frame) >= PtrW'(mem_end_q);
    stat_o.table_full = (count_q >= CntW'(MAX_REGIONS));
    stat_o.count_zero = (count_q == '0);
    stat_o.walk_last  = walk_last;
    stat_o.mod_done   = mod_done;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign out_frame_o  = out_frame_q;
  assign out_status_o = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_REGIONS))
    else $error("region count above table depth");

  a_walk_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> (walk_idx_q < count_q))
    else $error("walk index past filled entries");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (mod_rem < RemW'(FRAME_BYTES)))
    else $error("remainder not below frame size");

endmodule

`default_nettype wire

/* rtl/bfa_ctrl.sv */
// Controller state machine: sequences allocate, add and restart items and
// issues datapath commands. Depends on bfa_pkg.
`default_nettype none

module bfa_ctrl
  import bfa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire bfa_stat_t stat_i,
  output bfa_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_AFIN = 3'd3;
  localparam logic [2:0] S_MODW = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  status_e    res_status_q, res_status_d;
  logic       res_sel_q, res_sel_d;

  always_comb begin
    state_d       = state_q;
    res_status_d  = res_status_q;
    res_sel_d     = res_sel_q;
    cmd_o         = '0;
    cmd_o.res_status    = res_status_q;
    cmd_o.res_frame_sel = res_sel_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        res_status_d = ST_OK;
        res_sel_d    = 1'b0;
        state_d      = S_DONE;
        unique case (stat_i.mode)
          MODE_ALLOC: begin
            if (stat_i.oom) begin
              res_status_d = ST_OOM;
            end else begin
              cmd_o.init_walk = 1'b1;
              state_d = stat_i.count_zero ? S_AFIN : S_WALK;
            end
          end
          MODE_ADD: begin
            if (stat_i.table_full) begin
              res_status_d = ST_FULL;
            end else begin
              cmd_o.mod_start = 1'b1;
              state_d         = S_MODW;
            end
          end
          MODE_RESTART: begin
            cmd_o.restart = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_AFIN;
        end
      end
      S_AFIN: begin
        cmd_o.commit_alloc = 1'b1;
        res_status_d       = ST_OK;
        res_sel_d          = 1'b1;
        state_d            = S_DONE;
      end
      S_MODW: begin
        if (stat_i.mod_done) begin
          cmd_o.add_write = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= ST_OK;
      res_sel_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_sel_q    <= res_sel_d;
    end
  end

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !stat_i.count_zero)
    else $error("walking an empty region table");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> stat_i.out_free)
    else $error("result loaded over a pending beat");

  a_add_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MODW && stat_i.mod_done) |=> (state_q == S_DONE))
    else $error("add item did not finish after remainder");

endmodule

`default_nettype wire

/* rtl/bump_frame_allocator_core.sv */
// Bump frame allocator top level. Allocate: decode, walk of the N filled reserved
// regions (one region per cycle), commit, then the result beat.
// Add: decode, wait on the pipelined remainder unit, table write, then the result beat.
// Restart, unused mode, out of memory and table full: decode, then the result. One item at a
// time; the next input beat is taken once the result is in the output register.
// Async active-low reset clears pointer, region count, config registers and control.
`default_nettype none

module bump_frame_allocator_core
  import bfa_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned FRAME_BYTES = 4096
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bfa_in_if.sink     in_ch,
  bfa_out_if.source  out_ch,
  bfa_cfg_if.sink    cfg_ch
);

  bfa_cmd_t  cmd;
  bfa_stat_t stat;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfa_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_mode_i    (in_ch.mode),
    .in_first_i   (in_ch.region_first),
    .in_last_i    (in_ch.region_last),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_index_i  (cfg_ch.index),
    .cfg_data_i   (cfg_ch.data),
    .cfg_ready_o  (cfg_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_frame_o  (out_ch.frame_address),
    .out_status_o (out_ch.status)
  );

endmodule

`default_nettype wire

/* verif/tb_bump_frame_allocator_core.sv */
// Testbench for bump_frame_allocator_core: a directed stimulus table, then random
// config phases of restart/add/allocate/unused-mode traffic, each result beat checked in order.
// Depends on bfa_pkg, the bfa_*_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_bump_frame_allocator_core;
  import bfa_pkg::*;

  localparam int unsigned MAX_REGIONS  = 16;
  localparam int unsigned FRAME_BYTES  = 4096;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam logic [AddrW-1:0] ADDR_MAX    = {AddrW{1'b1}};
  localparam logic [63:0]      FRAME64     = 64'(FRAME_BYTES);

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [AddrW-1:0] frame;
    status_e          status;
  } alloc_reply_t;

  typedef struct packed {
    bit           fixed;
    alloc_reply_t reply;
  } reply_hint_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [ModeW-1:0]   mode;
    logic [CfgIdxW-1:0] idx;
    logic [AddrW-1:0]   a;     // region first, or register data
    logic [AddrW-1:0]   b;     // region last
    bit                 fixed;
    logic [AddrW-1:0]   frame;
    status_e            status;
  } plan_row_t;

  localparam plan_row_t PLAN [30] = '{
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OOM},
    '{ROW_ITEM, MODE_UNUSED,  CFG_MEM_START, ADDR_MAX, ADDR_MAX, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ADD,     CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_RESTART, CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_START, 48'h1000, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_END, 48'h10000, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_RESTART, CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h1000, ST_OK},
    '{ROW_ITEM, MODE_ADD,     CFG_MEM_START, 48'h2000, 48'h2fff, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ADD,     CFG_MEM_START, 48'h9000, 48'h5000, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ADD,     CFG_MEM_START, 48'h3800, 48'h3800, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_END, 48'h6000, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_START, 48'hffff_ffff_e000, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_END, ADDR_MAX, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_RESTART, CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ADD,     CFG_MEM_START, 48'hffff_ffff_e000, ADDR_MAX, 1'b1, 48'h0,
      ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ADD,     CFG_MEM_START, ADDR_MAX, 48'h0, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_START, ADDR_MAX, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_CFG,  MODE_ALLOC,   CFG_MEM_END, 48'h0, 48'h0, 1'b0, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_RESTART, CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OK},
    '{ROW_ITEM, MODE_ALLOC,   CFG_MEM_START, 48'h0, 48'h0, 1'b1, 48'h0, ST_OOM}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();
  bfa_cfg_if cfg_ch ();

  bump_frame_allocator_core #(
    .MAX_REGIONS (MAX_REGIONS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5ns clk_i = ~clk_i;

  // allocator shadow state
  logic [AddrW-1:0] mdl_start = '0;
  logic [AddrW-1:0] mdl_end   = '0;
  logic [AddrW-1:0] mdl_next  = '0;
  logic [AddrW-1:0] mdl_res_first [MAX_REGIONS];
  logic [AddrW-1:0] mdl_res_last  [MAX_REGIONS];
  int unsigned      mdl_count = 0;

  alloc_reply_t pending_replies [$];
  reply_hint_t  reply_hints [$];
  int unsigned  errors       = 0;
  int unsigned  results_seen = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  items_sent   = 0;
  int unsigned  steady_from  = 0;
  bit           steady_armed = 1'b0;
  bit           steady       = 1'b0;

  function automatic bit frame_hits(input logic [63:0] ptr, input logic [63:0] lo,
                                    input logic [63:0] hi);
    logic [63:0] tail;
    tail = ptr + FRAME64;
    return (ptr >= lo && ptr <= hi) || (tail > lo && tail <= hi) ||
           (ptr <= lo && tail >= hi);
  endfunction

  function automatic alloc_reply_t step_allocator(input logic [ModeW-1:0] mode,
                                                  input logic [AddrW-1:0] first,
                                                  input logic [AddrW-1:0] last);
    alloc_reply_t reply;
    logic [63:0]  ptr;
    logic [63:0]  hi;
    reply.frame  = '0;
    reply.status = ST_OK;
    ptr = 64'(mdl_next);
    case (mode)
      MODE_ALLOC: begin
        if (ptr + FRAME64 >= 64'(mdl_end)) begin
          reply.status = ST_OOM;
        end else begin
          for (int i = 0; i < int'(mdl_count); i++) begin
            hi = 64'(mdl_res_last[i]);
            if (frame_hits(ptr, 64'(mdl_res_first[i]), hi)) begin
              ptr = hi - (hi % FRAME64) + FRAME64;
            end
          end
          reply.frame = ptr[AddrW-1:0];
          mdl_next    = ptr[AddrW-1:0] + AddrW'(FRAME_BYTES);
        end
      end
      MODE_ADD: begin
        if (mdl_count >= MAX_REGIONS) begin
          reply.status = ST_FULL;
        end else begin
          mdl_res_first[mdl_count] = first;
          mdl_res_last[mdl_count]  = last;
          mdl_count++;
        end
      end
      MODE_RESTART: begin
        mdl_next  = mdl_start;
        mdl_count = 0;
      end
      default: ;
    endcase
    return reply;
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return {16'($urandom()), $urandom()};
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic offer_item(input logic [ModeW-1:0] mode, input logic [AddrW-1:0] first,
                            input logic [AddrW-1:0] last, input bit fixed = 1'b0,
                            input alloc_reply_t reply = '0);
    items_sent++;
    steady = steady_armed && items_sent >= steady_from && items_sent < steady_from + 100;
    while (!steady && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.region_first <= first;
    in_ch.region_last  <= last;
    reply_hints.push_back('{fixed, reply});
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic offer_region(input logic [AddrW-1:0] base);
    logic [AddrW-1:0] first;
    logic [AddrW-1:0] last;
    int unsigned      shape;
    shape = $urandom_range(9);
    first = base + AddrW'(FRAME_BYTES * $urandom_range(48));
    if ($urandom_range(1) != 0) first = first + AddrW'($urandom_range(FRAME_BYTES - 1));
    last = first + AddrW'(FRAME_BYTES * $urandom_range(3)) +
           AddrW'($urandom_range(FRAME_BYTES - 1));
    if (shape == 0) offer_item(MODE_ADD, last, first);
    else if (shape == 1) offer_item(MODE_ADD, rand_addr(), rand_addr());
    else offer_item(MODE_ADD, first, last);
  endtask

  // only with nothing in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] value);
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_replies.size() != 0);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] stop;
    int unsigned      kind;
    int unsigned      pick;
    int unsigned      random_base;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_ALLOC;
    in_ch.region_first = '0;
    in_ch.region_last  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_MEM_START;
    cfg_ch.data        = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_reg(PLAN[i].idx, PLAN[i].a);
      end else begin
        offer_item(PLAN[i].mode, PLAN[i].a, PLAN[i].b, PLAN[i].fixed,
                   '{PLAN[i].frame, PLAN[i].status});
      end
    end

    random_base  = items_sent;
    steady_from  = items_sent + 250;
    steady_armed = 1'b1;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      kind = $urandom_range(4);
      case (kind)
        0: begin
          start = AddrW'($urandom_range(24'hff_ffff));
          stop  = start + AddrW'(FRAME_BYTES * $urandom_range(40, 2)) +
                  AddrW'($urandom_range(FRAME_BYTES - 1));
        end
        1: begin
          start = '0;
          stop  = ADDR_MAX;
        end
        2: begin
          start = ADDR_MAX - AddrW'(FRAME_BYTES * $urandom_range(30, 1)) -
                  AddrW'($urandom_range(FRAME_BYTES - 1));
          stop  = ADDR_MAX;
        end
        3: begin
          start = rand_addr();
          stop  = rand_addr();
        end
        default: begin
          start = rand_addr() & ~AddrW'(FRAME_BYTES - 1);
          stop  = start + AddrW'(FRAME_BYTES * $urandom_range(64, 1));
        end
      endcase
      write_reg(CFG_MEM_START, start);
      write_reg(CFG_MEM_END, stop);
      offer_item(MODE_RESTART, rand_addr(), rand_addr());
      repeat ($urandom_range(50, 15)) begin
        pick = $urandom_range(99);
        if (pick < 50) offer_item(MODE_ALLOC, rand_addr(), rand_addr());
        else if (pick < 75) offer_region(start);
        else if (pick < 80) offer_item(MODE_RESTART, rand_addr(), rand_addr());
        else if (pick < 84) offer_item(MODE_UNUSED, rand_addr(), rand_addr());
        else if (pick < 94) offer_item(ModeW'($urandom()), rand_addr(), rand_addr());
        else repeat (MAX_REGIONS + 2) offer_region(start);
      end
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_replies.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : result_sink
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      // one long back-pressure window so the core fills and stalls its input
      if (!held && results_seen >= 80) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk_i) begin : scoreboard
    alloc_reply_t want;
    reply_hint_t  hint;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_MEM_START) mdl_start = cfg_ch.data;
        else if (cfg_ch.index == CFG_MEM_END) mdl_end = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        want = step_allocator(in_ch.mode, in_ch.region_first, in_ch.region_last);
        if (reply_hints.size() != 0) begin
          hint = reply_hints.pop_front();
          if (hint.fixed) want = hint.reply;
        end
        pending_replies.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_replies.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: frame_address %h status %0d", $time,
                   out_ch.frame_address, out_ch.status);
        end else begin
          want = pending_replies.pop_front();
          if (out_ch.frame_address !== want.frame) begin
            errors++;
            $display("%0t frame_address: expected %h, actual %h", $time, want.frame,
                     out_ch.frame_address);
          end
          if (out_ch.status !== want.status) begin
            errors++;
            $display("%0t status: expected %0d, actual %0d", $time, want.status,
                     out_ch.status);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t timeout: no beat for %0d cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

/* bump_frame_allocator_core.f */
rtl/bfa_pkg.sv
rtl/bfa_intf.sv
rtl/bfa_rem.sv
rtl/bfa_dp.sv
rtl/bfa_ctrl.sv
rtl/bump_frame_allocator_core.sv
verif/tb_bump_frame_allocator_core.sv
